// File: hdl/quadrature_knob_channel_adjuster_top_assert.svh
// Assertion macros used by the top level of the knob channel adjuster.
`ifndef QUADRATURE_KNOB_CHANNEL_ADJUSTER_TOP_ASSERT_SVH
`define QUADRATURE_KNOB_CHANNEL_ADJUSTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define QKCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define QKCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define QKCA_ASSERT_NOW(lbl, ante, cons)
`define QKCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/qkca_pkg.sv
// Types and constants of the knob channel adjuster.
`default_nettype none
package qkca_pkg;

  localparam int CFG_WIDTH   = 20;
  localparam int CHAN_WIDTH  = 8;
  localparam int CHAN_COUNT  = 4;
  localparam int MODE_WIDTH  = 2;

  localparam logic [CFG_WIDTH-1:0]  DEBOUNCE_RESET  = 20'd160000;
  localparam logic [CHAN_WIDTH-1:0] CHAN_MAX        = 8'd255;
  localparam logic [CHAN_WIDTH-1:0] INTENSITY_RESET = 8'd128;
  localparam logic [CHAN_WIDTH-1:0] COLOR_RESET     = 8'd127;

  // Channel selected by the mode
  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_INTENSITY = 2'd0,
    MODE_RED       = 2'd1,
    MODE_GREEN     = 2'd2,
    MODE_BLUE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef enum logic {
    BTN_IDLE = 1'b0,
    BTN_WAIT = 1'b1
  } btn_state_t;

  // One sample moving from the input register into the state update
  typedef struct packed {
    logic       fire;
    logic [1:0] phases;   // bit 0 is A, bit 1 is B
    logic       level;
  } tick_t;

  // Step for index {current pair, previous pair}; 00,01,11,10 counts up
  function automatic step_t step_lookup(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = STEP_DOWN;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/qkca_decode.sv
// Quadrature step decode and saturating update of the four channels.
`default_nettype none
module qkca_decode (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire qkca_pkg::tick_t                tick,
  input  wire qkca_pkg::mode_t                mode_sel,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]     intensity,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]     red,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]     green,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]     blue
);
  import qkca_pkg::*;

  logic [1:0]            previous_phases;
  logic [CHAN_WIDTH-1:0] chan [CHAN_COUNT];
  logic [CHAN_WIDTH-1:0] chan_next [CHAN_COUNT];
  logic [CHAN_WIDTH-1:0] sel_value;
  logic [CHAN_WIDTH-1:0] sel_next;
  step_t                 step;

  // Look up the step from the current and previous phase pairs
  assign step = step_lookup({tick.phases, previous_phases});
  assign sel_value = chan[mode_sel];

  // Saturate at both ends of the range
  always_comb begin
    sel_next = sel_value;
    unique case (step)
      STEP_UP:   if (sel_value != CHAN_MAX) sel_next = sel_value + 8'd1;
      STEP_DOWN: if (sel_value != '0) sel_next = sel_value - 8'd1;
      default:   sel_next = sel_value;
    endcase
  end

  // Write back only the selected channel
  always_comb begin
    for (int i = 0; i < CHAN_COUNT; i++) begin
      chan_next[i] = chan[i];
    end
    chan_next[mode_sel] = sel_next;
  end

  // Hold state except on a transfer through the update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_phases <= '0;
      chan[MODE_INTENSITY] <= INTENSITY_RESET;
      chan[MODE_RED]       <= COLOR_RESET;
      chan[MODE_GREEN]     <= COLOR_RESET;
      chan[MODE_BLUE]      <= COLOR_RESET;
    end else if (tick.fire) begin
      previous_phases <= tick.phases;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        chan[i] <= chan_next[i];
      end
    end
  end

  assign intensity = chan[MODE_INTENSITY];
  assign red       = chan[MODE_RED];
  assign green     = chan[MODE_GREEN];
  assign blue      = chan[MODE_BLUE];

endmodule
`default_nettype wire

// File: hdl/qkca_debounce.sv
// Button debounce counter and mode register.
`default_nettype none
module qkca_debounce #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qkca_pkg::tick_t               tick,
  input  wire logic [qkca_pkg::CFG_WIDTH-1:0] debounce_ticks,
  output qkca_pkg::mode_t                    mode_sel
);
  import qkca_pkg::*;

  btn_state_t            state;
  btn_state_t            state_next;
  logic [COUNT_BITS-1:0] debounce_count;
  logic                  button_prev;
  logic                  expire;
  logic                  start;
  logic                  advance;

  assign expire = (debounce_count <= COUNT_BITS'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BTN_IDLE: if (tick.fire && tick.level && !button_prev) state_next = BTN_WAIT;
      BTN_WAIT: if (tick.fire && expire) state_next = BTN_IDLE;
      default:  state_next = BTN_IDLE;
    endcase
  end

  // Outputs: load the count on an edge, advance the mode on expiry if pressed
  always_comb begin
    start   = 1'b0;
    advance = 1'b0;
    unique case (state)
      BTN_IDLE: start   = tick.fire && tick.level && !button_prev;
      BTN_WAIT: advance = tick.fire && expire && tick.level;
      default: begin
        start   = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BTN_IDLE;
      debounce_count <= '0;
      button_prev    <= 1'b0;
      mode_sel       <= MODE_INTENSITY;
    end else begin
      state <= state_next;
      if (tick.fire) begin
        button_prev <= tick.level;
        if (start) begin
          debounce_count <= COUNT_BITS'(debounce_ticks);
        end else if (state == BTN_WAIT) begin
          debounce_count <= expire ? '0 : debounce_count - COUNT_BITS'(1);
        end
      end
      if (advance) begin
        mode_sel <= mode_t'(mode_sel + 2'd1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/quadrature_knob_channel_adjuster_top.sv
// Top level of the quadrature knob channel adjuster.
`default_nettype none
// Takes one sample of the encoder phases and the button per transfer and
// returns the mode and the four channel values after that sample. One
// sample is taken every clock while the output side keeps up; the input
// register loads at the transfer, and the state registers that drive the
// result ports load when the held sample moves on, which a stall on the
// output side can hold back. The step decode and the saturating channel
// update sit in one short path between those registers.
// debounce_ticks may only be written while no sample is in flight.
module quadrature_knob_channel_adjuster_top #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [qkca_pkg::CFG_WIDTH-1:0]  cfg_write_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            phase_a,
  input  wire logic                            phase_b,
  input  wire logic                            button_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [qkca_pkg::MODE_WIDTH-1:0]      mode,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]      intensity,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]      red,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]      green,
  output logic [qkca_pkg::CHAN_WIDTH-1:0]      blue
);
  import qkca_pkg::*;

  logic [CFG_WIDTH-1:0] debounce_ticks;
  logic                 in_reg_valid;
  logic [1:0]           in_phases;
  logic                 in_level;
  logic                 fire;
  tick_t                tick;
  mode_t                mode_sel;

  // Move the held sample into the state when the result slot is free
  assign fire     = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && out_valid && out_stall;
  assign tick     = '{fire: fire, phases: in_phases, level: in_level};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_write_en) begin
      debounce_ticks <= cfg_write_data;
    end
  end

  // Input register: load on transfer, drop once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_phases <= {phase_b, phase_a};
      in_level  <= button_level;
    end
  end

  // Result valid: set on an update, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  qkca_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .mode_sel  (mode_sel),
    .intensity (intensity),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  qkca_debounce #(
    .COUNT_BITS (COUNT_BITS)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .debounce_ticks (debounce_ticks),
    .mode_sel       (mode_sel)
  );

  assign mode = mode_sel;

`include "quadrature_knob_channel_adjuster_top_assert.svh"

  `QKCA_ASSERT_NOW(a_no_update_while_held, out_valid && out_stall, !fire)
  `QKCA_ASSERT_NEXT(a_mode_only_on_update, !fire, $stable(mode))
  `QKCA_ASSERT_NEXT(a_values_only_on_update, !fire,
    $stable(intensity) && $stable(red) && $stable(green) && $stable(blue))
  `QKCA_ASSERT_NEXT(a_one_channel_moves, fire,
    $countones({intensity != $past(intensity), red != $past(red),
                green != $past(green), blue != $past(blue)}) <= 1)
  `QKCA_ASSERT_NEXT(a_update_gives_result, fire, out_valid)

endmodule
`default_nettype wire
